// ===== design/jfns_pkg.sv =====
// Shared constants and types of the four-neighbor stencil unit.
`timescale 1ns / 1ps
`default_nettype none

package jfns_pkg;

  localparam int GRID_W_BITS = 11;
  localparam int GRID_H_BITS = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [GRID_W_BITS-1:0] GRID_WIDTH_RESET  = 11'd1024;
  localparam logic [GRID_H_BITS-1:0] GRID_HEIGHT_RESET = 16'd1024;

  localparam int SAMPLE_W  = 32;
  localparam int AVG_W     = 32;
  localparam int OUT_ROW_W = 16;
  localparam int OUT_COL_W = 10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = 3;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } jfns_meta_t;

  localparam int META_W = $bits(jfns_meta_t);

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } jfns_qstat_t;

endpackage

`default_nettype wire

// ===== design/jfns_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module jfns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/jfns_front.sv =====
// Front part: configuration, raster counters, row buffers and operand gathering.
`timescale 1ns / 1ps
`default_nettype none

module jfns_front import jfns_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 32,
  localparam int QDATA_W = 4 * SAMPLE_BITS + META_W
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                       push_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  output logic                            full_o,
  input  wire jfns_qstat_t                qstat_i,
  output logic                            q_push_o,
  output logic [QDATA_W-1:0]              q_data_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW_MIN = $clog2(MAX_WIDTH + 1);
  localparam int EW_W   = (GRID_W_BITS > EW_MIN) ? GRID_W_BITS : EW_MIN;
  localparam int QSUM_W = QCNT_W + 1;

  logic [GRID_W_BITS-1:0] grid_width_q;
  logic [GRID_H_BITS-1:0] grid_height_q;
  logic [EW_W-1:0]        width_ext;
  logic [EW_W-1:0]        eff_width;
  logic [COL_W-1:0]       col_last;
  logic [GRID_H_BITS-1:0] row_last;

  logic [COL_W-1:0]       col_q;
  logic [GRID_H_BITS-1:0] row_q;
  logic                   accept;

  logic signed [SAMPLE_BITS-1:0] sample_ext;

  logic                   f1_valid_q;
  logic                   f1_emit_q;
  logic [SAMPLE_BITS-1:0] f1_sample_q;
  logic [COL_W-1:0]       f1_col_q;
  jfns_meta_t             f1_meta_q;

  logic [SAMPLE_BITS-1:0] rd_prev;
  logic [SAMPLE_BITS-1:0] rd_prev2;
  logic [SAMPLE_BITS-1:0] prev_d1_q;
  logic [SAMPLE_BITS-1:0] prev_d2_q;
  logic [SAMPLE_BITS-1:0] prev2_d1_q;
  logic [SAMPLE_BITS-1:0] sample_d1_q;

  // Effective frame size: width clamped to [3, MAX_WIDTH], height raised to 3.
  assign width_ext = EW_W'(grid_width_q);
  assign eff_width = (width_ext < EW_W'(3)) ? EW_W'(3) :
                     ((width_ext > EW_W'(MAX_WIDTH)) ? EW_W'(MAX_WIDTH) : width_ext);
  assign col_last  = COL_W'(eff_width - EW_W'(1));
  assign row_last  = (grid_height_q < GRID_H_BITS'(3)) ? GRID_H_BITS'(2) :
                     (grid_height_q - GRID_H_BITS'(1));

  // Credit check: the beat in flight still needs a queue slot.
  assign full_o = (QSUM_W'(qstat_i.count) + QSUM_W'(f1_valid_q)) >= QSUM_W'(QUEUE_DEPTH);
  assign accept = push_i && !full_o;

  assign sample_ext = SAMPLE_BITS'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RESET;
      grid_height_q <= GRID_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[GRID_W_BITS-1:0];
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i[GRID_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Any register write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == col_last) begin
        col_q <= '0;
        row_q <= (row_q == row_last) ? '0 : (row_q + GRID_H_BITS'(1));
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_sample_q    <= sample_ext;
      f1_col_q       <= col_q;
      f1_emit_q      <= (row_q >= GRID_H_BITS'(2)) && (col_q >= COL_W'(2));
      f1_meta_q.row  <= row_q - GRID_H_BITS'(1);
      f1_meta_q.col  <= OUT_COL_W'(col_q - COL_W'(1));
      f1_meta_q.last <= (row_q == row_last) && (col_q == col_last);
    end
  end

  // The previous-row buffer is read when a beat is taken; in the next cycle the beat
  // overwrites it and pushes the old entry down into the buffer two rows back.
  jfns_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram_prev (
    .clk_i   (clk_i),
    .we_i    (f1_valid_q),
    .waddr_i (f1_col_q),
    .wdata_i (f1_sample_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_prev)
  );

  jfns_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram_prev2 (
    .clk_i   (clk_i),
    .we_i    (f1_valid_q),
    .waddr_i (f1_col_q),
    .wdata_i (rd_prev),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_prev2)
  );

  // Short history of the last beats gives the left, upper and lower neighbors.
  always_ff @(posedge clk_i) begin
    if (f1_valid_q) begin
      prev_d1_q   <= rd_prev;
      prev_d2_q   <= prev_d1_q;
      prev2_d1_q  <= rd_prev2;
      sample_d1_q <= f1_sample_q;
    end
  end

  assign q_push_o = f1_valid_q && f1_emit_q;
  assign q_data_o = {prev_d2_q, prev2_d1_q, rd_prev, sample_d1_q, f1_meta_q};

  a_last_is_interior: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (f1_valid_q && f1_meta_q.last) |-> f1_emit_q
  ) else $error("frame_last marked on a cell that gives no result");

endmodule

`default_nettype wire

// ===== design/jfns_queue.sv =====
// Short FIFO of gathered operand sets between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module jfns_queue import jfns_pkg::*; #(
  parameter int WIDTH = 155
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output jfns_qstat_t           qstat_o
);

  logic [WIDTH-1:0]  slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : (wptr_q + QPTR_W'(1));
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : (rptr_q + QPTR_W'(1));
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  assign data_o        = slots_q[rptr_q];
  assign qstat_o.count = count_q;
  assign qstat_o.empty = (count_q == '0);

  a_no_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != QCNT_W'(QUEUE_DEPTH))
  ) else $error("operand queue written while full");

  a_no_underflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0)
  ) else $error("operand queue read while empty");

endmodule

`default_nettype wire

// ===== design/jfns_back.sv =====
// Back part: four-operand sum, floor divide by four and the result register.
`timescale 1ns / 1ps
`default_nettype none

module jfns_back import jfns_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  localparam int QDATA_W = 4 * SAMPLE_BITS + META_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [QDATA_W-1:0]    q_data_i,
  input  wire jfns_qstat_t           qstat_i,
  output logic                       q_pop_o,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic signed [AVG_W-1:0]    average_o,
  output logic [OUT_ROW_W-1:0]       out_row_o,
  output logic [OUT_COL_W-1:0]       out_col_o,
  output logic                       frame_last_o
);

  localparam int SUM_W = SAMPLE_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] left;
  logic signed [SAMPLE_BITS-1:0] above;
  logic signed [SAMPLE_BITS-1:0] right;
  logic signed [SAMPLE_BITS-1:0] below;
  jfns_meta_t                    meta;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       quarter;

  logic                    out_valid_q;
  logic signed [AVG_W-1:0] average_q;
  jfns_meta_t              meta_q;
  logic                    take;

  assign left  = q_data_i[META_W + 4*SAMPLE_BITS - 1 -: SAMPLE_BITS];
  assign above = q_data_i[META_W + 3*SAMPLE_BITS - 1 -: SAMPLE_BITS];
  assign right = q_data_i[META_W + 2*SAMPLE_BITS - 1 -: SAMPLE_BITS];
  assign below = q_data_i[META_W + SAMPLE_BITS - 1 -: SAMPLE_BITS];
  assign meta  = q_data_i[META_W-1:0];

  // Two guard bits keep the sum exact; the arithmetic shift rounds toward minus infinity.
  assign sum     = SUM_W'(left) + SUM_W'(above) + SUM_W'(right) + SUM_W'(below);
  assign quarter = sum >>> 2;

  assign take    = !qstat_i.empty && (!out_valid_q || pop_i);
  assign q_pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      average_q <= AVG_W'(quarter);
      meta_q    <= meta;
    end
  end

  assign empty_o      = !out_valid_q;
  assign average_o    = average_q;
  assign out_row_o    = meta_q.row;
  assign out_col_o    = meta_q.col;
  assign frame_last_o = meta_q.last;

  a_fill_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!qstat_i.empty && !out_valid_q) |=> out_valid_q
  ) else $error("waiting operands not moved into the empty result register");

endmodule

`default_nettype wire

// ===== design/jacobi_four_neighbor_stencil_unit.sv =====
// Top level of the streaming four-neighbor Jacobi stencil unit.
//
// Grid samples enter in raster order as beats on the push/full side. For every
// interior cell the unit returns one beat on the empty/pop side: the floor of
// the mean of its upper, lower, left and right neighbors, with its row, its
// column and a flag on the last interior cell of the frame. Boundary rows and
// columns give no beat. A cell's result is registered once the sample
// below-right of it has arrived. Throughput is one sample per cycle while full
// is low; it is set by the single read and write port of each of the two row
// buffers, used once per sample. The configuration port writes grid_width
// (index 0) or grid_height (index 1); any write restarts the frame at row 0,
// column 0. Writes are to be made while idle; the block does not enforce it.
// Reset restores 1024 x 1024 and restarts the frame; the row buffers are not
// cleared, since each entry is written before it is read within a frame.
// When the receiver stalls, results collect in a four-deep operand queue and a
// result register; full rises once the queue has no room left for the beats in
// flight, and falls again as soon as a result is popped.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_four_neighbor_stencil_unit import jfns_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic signed [AVG_W-1:0]         average_o,
  output logic [OUT_ROW_W-1:0]            out_row_o,
  output logic [OUT_COL_W-1:0]            out_col_o,
  output logic                            frame_last_o
);

  localparam int QDATA_W = 4 * SAMPLE_BITS + META_W;

  jfns_qstat_t        qstat;
  logic               q_push;
  logic               q_pop;
  logic [QDATA_W-1:0] q_wdata;
  logic [QDATA_W-1:0] q_rdata;

  jfns_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .sample_i   (sample_i),
    .full_o     (full),
    .qstat_i    (qstat),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  jfns_queue #(
    .WIDTH (QDATA_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .qstat_o (qstat)
  );

  jfns_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (q_rdata),
    .qstat_i      (qstat),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .average_o    (average_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_last_o (frame_last_o)
  );

endmodule

`default_nettype wire
